### hdl/bitmap_block_allocator_top_defines.svh
// Assertion macros shared by the bitmap block allocator modules.
`ifndef BITMAP_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("bitmap allocator check failed");
// Next-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("bitmap allocator check failed");
`else
`define BBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hdl/bba_pkg.sv
// Shared constants, payload types and search functions of the bitmap block allocator.
package bba_pkg;

    localparam int NUM_BLOCKS  = 16384;
    localparam int CHUNK_BITS  = 4096;
    localparam int WORD_BITS   = 32;
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int WORD_COUNT  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int CHUNK_COUNT = (NUM_BLOCKS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int IDX_W       = $clog2(NUM_BLOCKS);
    localparam int HW_W        = IDX_W + 1;
    localparam int WADDR_W     = $clog2(WORD_COUNT);
    localparam int LIM_W       = $clog2(WORD_COUNT + 1);
    localparam int GRP_COUNT   = WORD_COUNT / WORD_BITS;
    localparam int GRP_W       = $clog2(GRP_COUNT);
    localparam int CHUNK_SHIFT = $clog2(CHUNK_BITS);
    localparam int CHUNK_W     = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
    localparam int CNT_W       = $clog2(CHUNK_BITS) + 1;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BLOCK  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ENABLE = CFG_IDX_W'(1);

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_READ_ONLY = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_BELOW     = 3'd3;
    localparam logic [2:0] ST_NOT_ALLOC = 3'd4;

    typedef struct packed {
        logic        kind;
        logic [31:0] block_number;
    } t_req;

    typedef struct packed {
        logic [31:0] allocated_block;
        logic [2:0]  status;
    } t_res;

    // Write of one word's full flag into the summary.
    typedef struct packed {
        logic               valid;
        logic [WADDR_W-1:0] word;
        logic               full;
    } t_sum_upd;

    // Answer of the summary search: lowest word that still has a clear bit.
    typedef struct packed {
        logic               valid;
        logic               found;
        logic [WADDR_W-1:0] word;
    } t_sum_res;

    // Lowest set bit, bit zero first; the top bit of the result flags a hit.
    function automatic logic [BIT_W:0] lowest_set32(input logic [WORD_BITS-1:0] v);
        logic [BIT_W:0] res;
        res = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (v[b]) begin
                res = {1'b1, BIT_W'(b)};
            end
        end
        return res;
    endfunction

    // First clear bit of a bitmap word, most significant bit taken as position zero.
    function automatic logic [BIT_W:0] first_zero_msb(input logic [WORD_BITS-1:0] w);
        logic [BIT_W:0] res;
        res = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!w[WORD_BITS-1-b]) begin
                res = {1'b1, BIT_W'(b)};
            end
        end
        return res;
    endfunction

    // Lowest set flag among the summary groups.
    function automatic logic [GRP_W:0] lowest_grp(input logic [GRP_COUNT-1:0] v);
        logic [GRP_W:0] res;
        res = '0;
        for (int g = GRP_COUNT - 1; g >= 0; g--) begin
            if (v[g]) begin
                res = {1'b1, GRP_W'(g)};
            end
        end
        return res;
    endfunction

endpackage

### hdl/bba_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
module bba_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/bba_summary.sv
// Word-full summary of the bitmap and its two-stage search for the first non-full word.
`include "bitmap_block_allocator_top_defines.svh"
module bba_summary
    import bba_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [LIM_W-1:0] i_limit,
    input  t_sum_upd         i_upd,
    output t_sum_res         o_res
);

    // One flag per bitmap word, grouped in rows of 32. Flags of words at or
    // above the limit were never written and count as not full.
    logic [WORD_BITS-1:0] r_sum [GRP_COUNT];
    logic [WORD_BITS-1:0] eff   [GRP_COUNT];
    logic [GRP_COUNT-1:0] grp_clear;
    logic [LIM_W-1:0]     r_limit;
    logic [LIM_W-1:0]     lim_sel;
    logic                 r_s1;
    logic                 r_gfound;
    logic [GRP_W-1:0]     r_grp;
    logic [GRP_W:0]       grp_hit;
    logic [BIT_W:0]       word_hit;
    logic                 r_res_valid;
    logic                 r_found;
    logic [WADDR_W-1:0]   r_word;

    assign lim_sel = r_s1 ? r_limit : i_limit;

    always_comb begin
        for (int g = 0; g < GRP_COUNT; g++) begin
            for (int b = 0; b < WORD_BITS; b++) begin
                eff[g][b] = r_sum[g][b] & ((g * WORD_BITS + b) < int'(lim_sel));
            end
            grp_clear[g] = ~&eff[g];
        end
    end

    assign grp_hit  = lowest_grp(grp_clear);
    assign word_hit = lowest_set32(~eff[r_grp]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1        <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_s1        <= i_start;
            r_res_valid <= r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_limit  <= i_limit;
            r_gfound <= grp_hit[GRP_W];
            r_grp    <= grp_hit[GRP_W-1:0];
        end
        if (r_s1) begin
            r_found <= r_gfound;
            r_word  <= {r_grp, word_hit[BIT_W-1:0]};
        end
        if (i_upd.valid) begin
            r_sum[i_upd.word[WADDR_W-1:BIT_W]][i_upd.word[BIT_W-1:0]] <= i_upd.full;
        end
    end

    assign o_res = '{valid: r_res_valid, found: r_found, word: r_word};

    `BBA_ASSERT_IMPL(a_no_upd_in_search, i_clk, i_rst_n, i_upd.valid, !r_s1 && !i_start)
    `BBA_ASSERT_NEXT(a_stage_follows, i_clk, i_rst_n, r_s1, r_res_valid)
    `BBA_ASSERT_NEXT(a_no_spurious_res, i_clk, i_rst_n, !r_s1, !r_res_valid)

endmodule

### hdl/bitmap_block_allocator_top.sv
// Top level of the first-fit bitmap block allocator: control sequencer and registers.
//
//  Channel   Direction  Handshake                 Beat contents
//  request   in         i_valid / o_ready         i_data  : t_req (kind, block_number)
//  result    out        o_valid / i_ready         o_data  : t_res (allocated_block, status)
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One request is in work at a time. An allocate passes from acceptance through the two
// summary search stages, ending in the bitmap RAM read, then picks the bit, checks and
// writes back, loads the result register and returns to idle. A free reads the word, then
// checks and writes back; an allocate that finds no clear word, and a refused request, go to the result.
// The bitmap RAM is not cleared after reset; words at or above the high-water word count
// read as zero. A stalled result holds the sequencer; configuration beats are always taken.
`include "bitmap_block_allocator_top_defines.svh"
module bitmap_block_allocator_top
    import bba_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_req                 i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_res                 o_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRCH  = 3'd1;
    localparam logic [2:0] S_AREAD = 3'd2;
    localparam logic [2:0] S_AEXT  = 3'd3;
    localparam logic [2:0] S_FREAD = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]         r_state, n_state;
    logic [31:0]        r_first_block;
    logic               r_write_enable;
    logic [HW_W-1:0]    r_hw, n_hw;
    logic [CNT_W-1:0]   r_chunk_cnt [CHUNK_COUNT];
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [WADDR_W-1:0] r_word, n_word;
    logic [WORD_BITS-1:0] r_wdata, n_wdata;
    logic               r_rd_ok, n_rd_ok;
    t_res               r_res, n_res;
    t_res               r_out;
    logic               r_out_valid;

    logic               req_acc;
    logic               out_load;
    logic [HW_W:0]      lim_sum;
    logic [LIM_W-1:0]   limit;
    logic               search_start;
    t_sum_res           sum_res;
    t_sum_upd           sum_upd;
    logic               ram_we, ram_re;
    logic [WADDR_W-1:0] ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata, rd_word;
    logic [WORD_BITS-1:0] bit_mask;
    logic [BIT_W:0]     zero_hit;
    logic [31:0]        free_diff;
    logic [32:0]        alloc_blk;
    logic               cnt_inc, cnt_dec;
    logic [CHUNK_W-1:0] cnt_sel;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign req_acc     = i_valid && o_ready;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || i_ready);

    // Words below the high-water mark, rounded up, are the ones ever written.
    assign lim_sum = {1'b0, r_hw} + (HW_W + 1)'(WORD_BITS - 1);
    assign limit   = LIM_W'(lim_sum >> BIT_W);

    assign rd_word   = r_rd_ok ? ram_rdata : '0;
    assign bit_mask  = {1'b1, {(WORD_BITS - 1){1'b0}}} >> r_idx[BIT_W-1:0];
    assign zero_hit  = first_zero_msb(rd_word);
    assign free_diff = i_data.block_number - r_first_block;
    assign alloc_blk = {1'b0, r_first_block} + 33'(r_idx);
    assign cnt_sel   = CHUNK_W'(r_idx >> CHUNK_SHIFT);

    bba_ram #(
        .DEPTH (WORD_COUNT),
        .WIDTH (WORD_BITS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bba_summary u_summary (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (search_start),
        .i_limit (limit),
        .i_upd   (sum_upd),
        .o_res   (sum_res)
    );

    always_comb begin
        n_state      = r_state;
        n_hw         = r_hw;
        n_idx        = r_idx;
        n_word       = r_word;
        n_wdata      = r_wdata;
        n_rd_ok      = r_rd_ok;
        n_res        = r_res;
        search_start = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = r_word;
        ram_we       = 1'b0;
        ram_waddr    = r_idx[IDX_W-1:BIT_W];
        ram_wdata    = r_wdata;
        sum_upd      = '0;
        cnt_inc      = 1'b0;
        cnt_dec      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_res.allocated_block = '0;
                    n_res.status          = ST_OK;
                    if (i_data.kind == KIND_ALLOC) begin
                        if (!r_write_enable) begin
                            n_res.status = ST_READ_ONLY;
                            n_state      = S_DONE;
                        end else begin
                            search_start = 1'b1;
                            n_state      = S_SRCH;
                        end
                    end else if (i_data.block_number < r_first_block) begin
                        n_res.status = ST_BELOW;
                        n_state      = S_DONE;
                    end else if (|free_diff[31:IDX_W]) begin
                        // Beyond the bitmap: never allocated.
                        n_res.status = ST_NOT_ALLOC;
                        n_state      = S_DONE;
                    end else begin
                        n_idx     = free_diff[IDX_W-1:0];
                        ram_re    = 1'b1;
                        ram_raddr = free_diff[IDX_W-1:BIT_W];
                        n_rd_ok   = {1'b0, free_diff[IDX_W-1:BIT_W]} < limit;
                        n_state   = S_FREAD;
                    end
                end
            end
            S_SRCH: begin
                if (sum_res.valid) begin
                    if (sum_res.found) begin
                        ram_re    = 1'b1;
                        ram_raddr = sum_res.word;
                        n_word    = sum_res.word;
                        n_rd_ok   = {1'b0, sum_res.word} < limit;
                        n_state   = S_AREAD;
                    end else begin
                        n_res.status = ST_FULL;
                        n_state      = S_DONE;
                    end
                end
            end
            S_AREAD: begin
                // The chosen word holds a clear bit, never above the mark.
                n_idx   = {r_word, zero_hit[BIT_W-1:0]};
                n_wdata = rd_word;
                n_state = S_AEXT;
            end
            S_AEXT: begin
                if (alloc_blk[32]) begin
                    n_res.status = ST_FULL;
                end else begin
                    ram_we       = 1'b1;
                    ram_wdata    = r_wdata | bit_mask;
                    sum_upd.valid = 1'b1;
                    sum_upd.word = r_idx[IDX_W-1:BIT_W];
                    sum_upd.full = &(r_wdata | bit_mask);
                    cnt_dec      = 1'b1;
                    if ({1'b0, r_idx} >= r_hw) begin
                        n_hw = HW_W'(r_idx) + HW_W'(1);
                    end
                    n_res.allocated_block = alloc_blk[31:0];
                    n_res.status          = ST_OK;
                end
                n_state = S_DONE;
            end
            S_FREAD: begin
                if ((rd_word & bit_mask) == '0) begin
                    n_res.status = ST_NOT_ALLOC;
                end else begin
                    ram_we        = 1'b1;
                    ram_wdata     = rd_word & ~bit_mask;
                    sum_upd.valid = 1'b1;
                    sum_upd.word  = r_idx[IDX_W-1:BIT_W];
                    sum_upd.full  = 1'b0;
                    cnt_inc       = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and registers with a reset value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_first_block  <= 32'd1;
            r_write_enable <= 1'b0;
            r_hw           <= '0;
            r_out_valid    <= 1'b0;
            for (int c = 0; c < CHUNK_COUNT; c++) begin
                r_chunk_cnt[c] <= CNT_W'(CHUNK_BITS);
            end
        end else begin
            r_state <= n_state;
            r_hw    <= n_hw;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FIRST_BLOCK:  r_first_block  <= i_cfg_data;
                    CFG_WRITE_ENABLE: r_write_enable <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            // Per-chunk free counts saturate at empty and at full.
            if (cnt_dec && (r_chunk_cnt[cnt_sel] != '0)) begin
                r_chunk_cnt[cnt_sel] <= r_chunk_cnt[cnt_sel] - CNT_W'(1);
            end else if (cnt_inc && (r_chunk_cnt[cnt_sel] < CNT_W'(CHUNK_BITS))) begin
                r_chunk_cnt[cnt_sel] <= r_chunk_cnt[cnt_sel] + CNT_W'(1);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_word  <= n_word;
        r_wdata <= n_wdata;
        r_rd_ok <= n_rd_ok;
        r_res   <= n_res;
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `BBA_ASSERT_NEXT(a_hw_monotone, i_clk, i_rst_n, 1'b1, r_hw >= $past(r_hw))
    `BBA_ASSERT_IMPL(a_hw_bounded, i_clk, i_rst_n, 1'b1, r_hw <= HW_W'(NUM_BLOCKS))
    `BBA_ASSERT_IMPL(a_search_in_srch, i_clk, i_rst_n, sum_res.valid, r_state == S_SRCH)

endmodule

### tb/bitmap_block_allocator_checker.sv
// Checker for the bitmap block allocator: tracks the bitmap, predicts every result and compares.
module bitmap_block_allocator_checker
    import bba_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    input  logic                 i_req_ready,
    input  t_req                 i_req,
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    input  t_res                 i_res,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int REPORT_LIMIT = 100;

    logic [31:0]      used_map [WORD_COUNT];
    logic [HW_W-1:0]  high_mark;
    logic [CNT_W-1:0] chunk_free [CHUNK_COUNT];
    logic [31:0]      base_block;
    logic             alloc_enabled;
    t_res             due_answers [$];
    int               fails = 0;

    // Lowest clear index below the high-water mark, else the mark itself.
    function automatic int lowest_clear_index();
        int span;
        span = (int'(high_mark) + 31) / 32;
        if (span > WORD_COUNT) span = WORD_COUNT;
        for (int w = 0; w < span; w++) begin
            if (used_map[w] != '1) begin
                for (int b = 0; b < 32; b++) begin
                    if (!used_map[w][31 - b]) begin
                        return (w * 32 + b < int'(high_mark)) ? w * 32 + b : int'(high_mark);
                    end
                end
            end
        end
        return int'(high_mark);
    endfunction

    // Applies one allocate or free to the tracked bitmap and returns its answer.
    task automatic serve_request(input t_req r, output t_res ans);
        int          idx;
        int          c;
        logic [32:0] wide;
        logic [31:0] off;
        ans.allocated_block = '0;
        ans.status          = ST_OK;
        if (r.kind == KIND_ALLOC) begin
            if (!alloc_enabled) begin
                ans.status = ST_READ_ONLY;
            end else begin
                idx  = lowest_clear_index();
                wide = {1'b0, base_block} + 33'(idx);
                if (idx >= NUM_BLOCKS || wide[32]) begin
                    ans.status = ST_FULL;
                end else begin
                    used_map[idx / 32][31 - idx % 32] = 1'b1;
                    if (idx >= int'(high_mark)) high_mark = HW_W'(idx + 1);
                    c = idx / CHUNK_BITS;
                    if (chunk_free[c] != '0) chunk_free[c] = chunk_free[c] - CNT_W'(1);
                    ans.allocated_block = wide[31:0];
                end
            end
        end else if (r.block_number < base_block) begin
            ans.status = ST_BELOW;
        end else begin
            off = r.block_number - base_block;
            if (off >= NUM_BLOCKS) begin
                ans.status = ST_NOT_ALLOC;
            end else if (!used_map[off / 32][31 - off % 32]) begin
                ans.status = ST_NOT_ALLOC;
            end else begin
                used_map[off / 32][31 - off % 32] = 1'b0;
                c = off / CHUNK_BITS;
                if (chunk_free[c] < CNT_W'(CHUNK_BITS)) chunk_free[c] = chunk_free[c] + CNT_W'(1);
            end
        end
    endtask

    always @(posedge i_clk) begin : track
        t_res want;
        if (!i_rst_n) begin
            for (int w = 0; w < WORD_COUNT; w++) used_map[w] = '0;
            for (int c = 0; c < CHUNK_COUNT; c++) chunk_free[c] = CNT_W'(CHUNK_BITS);
            high_mark     = '0;
            base_block    = 32'd1;
            alloc_enabled = 1'b0;
            due_answers.delete();
        end else begin
            // The older answer leaves before a request taken at the same edge joins.
            if (i_res_valid && i_res_ready) begin
                if (due_answers.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_LIMIT)
                        $error("unexpected result beat: allocated_block %0h status %0d",
                               i_res.allocated_block, i_res.status);
                end else begin
                    want = due_answers.pop_front();
                    if (i_res.allocated_block !== want.allocated_block) begin
                        fails++;
                        if (fails <= REPORT_LIMIT)
                            $error("allocated_block: expected %0h, got %0h",
                                   want.allocated_block, i_res.allocated_block);
                    end
                    if (i_res.status !== want.status) begin
                        fails++;
                        if (fails <= REPORT_LIMIT)
                            $error("status: expected %0d, got %0d", want.status, i_res.status);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FIRST_BLOCK:  base_block = i_cfg_data;
                    CFG_WRITE_ENABLE: alloc_enabled = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready) begin
                serve_request(i_req, want);
                due_answers.push_back(want);
            end
        end
        o_fail_count <= fails;
        o_pending    <= due_answers.size();
    end

endmodule

### tb/tb_bitmap_block_allocator_top.sv
// Testbench top of the bitmap block allocator: stimulus, handshake timing and verdict.
module tb_bitmap_block_allocator_top;
    import bba_pkg::*;

    // Register indexes past the end of the register map; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

    localparam int MAX_GAP       = 17;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 90;
    localparam int BURST_ITEMS   = 40;

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_ready;
    t_req                 req_beat;
    logic                 res_valid;
    logic                 res_ready;
    t_res                 res_beat;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    int fail_count;
    int pending;

    // The first block number currently programmed. It only changes while the block is
    // idle, so the result process can turn every granted block back into a bitmap index.
    logic [31:0] cur_base = 32'd1;
    // Bitmap indices seen granted; frees draw most of their targets from here.
    logic [31:0] held_indices [$];

    bit no_idle      = 1'b0;
    bit hold_results = 1'b0;
    int req_calm     = 0;
    int res_calm     = 0;
    int quiet_cycles = 0;

    bitmap_block_allocator_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (req_valid),
        .o_ready     (req_ready),
        .i_data      (req_beat),
        .o_valid     (res_valid),
        .i_ready     (res_ready),
        .o_data      (res_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    bitmap_block_allocator_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req        (req_beat),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_res        (res_beat),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The run is declared hung when no channel moves a beat for too long. The longest
    // legal quiet stretch is the receiver's deliberate hold-off plus one request's work.
    always @(posedge clk) begin : watchdog
        if (!rst_n || (req_valid && req_ready) || (res_valid && res_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Idle cycles before the next beat of one side. Now and then a side enters a calm
    // stretch in which it does not idle at all, so back-to-back beats are exercised too.
    function automatic int next_gap(input bit for_results);
        if (no_idle) return 0;
        if (for_results && res_calm > 0) begin
            res_calm--;
            return 0;
        end
        if (!for_results && req_calm > 0) begin
            req_calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            if (for_results) res_calm = $urandom_range(8, 40);
            else req_calm = $urandom_range(8, 40);
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Offers one request beat and returns at the edge that accepts it. Valid is left
    // high, so a following beat with no gap goes out without a bubble.
    task automatic send_req(input logic kind, input logic [31:0] blk);
        int gap;
        gap = next_gap(1'b0);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_beat  <= '{kind: kind, block_number: blk};
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stops offering requests and waits until every predicted result has been returned.
    // The first edge lets the checker count a request accepted at the calling edge.
    task automatic drain_all();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Registers are only rewritten once the block has gone quiet.
    task automatic set_config(input logic [31:0] base, input logic enable);
        drain_all();
        cfg_write(CFG_FIRST_BLOCK, base);
        cfg_write(CFG_WRITE_ENABLE, {31'b0, enable});
        cur_base = base;
    endtask

    // Picks the target of a free. Most targets are blocks known to be granted, which
    // keeps the bitmap churning, and an entry sometimes left behind gives a later double free;
    // the rest are never-granted blocks near the mark, blocks below the first block, blocks
    // around the end of the bitmap and fully random numbers.
    task automatic pick_free_block(output logic [31:0] blk);
        int sel;
        int k;
        sel = $urandom_range(0, 99);
        if (sel < 55 && held_indices.size() > 0) begin
            k   = $urandom_range(0, held_indices.size() - 1);
            blk = cur_base + held_indices[k];
            // Leaving the entry behind sometimes produces a later double free.
            if ($urandom_range(0, 6) != 0) held_indices.delete(k);
        end else if (sel < 70) begin
            blk = cur_base + $urandom_range(0, 700);
        end else if (sel < 80) begin
            blk = (cur_base == 32'd0) ? 32'd0 : $urandom_range(0, cur_base - 1);
        end else if (sel < 90) begin
            blk = cur_base + NUM_BLOCKS - 2 + $urandom_range(0, 3);
        end else begin
            blk = $urandom();
        end
    endtask

    task automatic random_item();
        logic [31:0] blk;
        if ($urandom_range(0, 1) == 0) begin
            send_req(KIND_ALLOC, $urandom());
        end else begin
            pick_free_block(blk);
            send_req(KIND_FREE, blk);
        end
    endtask

    // Result side: takes one beat at a time after a random gap, or after the long
    // hold-off when the stimulus asks for one. Granted blocks feed the free pool.
    initial begin : result_sink
        int gap;
        res_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_results) begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end else begin
                gap = next_gap(1'b1);
                if (gap > 0) begin
                    res_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
            if (res_beat.status == ST_OK && res_beat.allocated_block != '0)
                held_indices.push_back(res_beat.allocated_block - cur_base);
        end
    end

    initial begin : stimulus
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_beat  <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_FIRST_BLOCK;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: first block 1 and writes disabled, so an allocate is refused.
        // Frees check the below-first-block, never-granted and past-the-end answers.
        send_req(KIND_ALLOC, 32'hffff_ffff);
        send_req(KIND_FREE, 32'd0);
        send_req(KIND_FREE, 32'd1);
        send_req(KIND_FREE, 32'hffff_ffff);

        // Enable writes; the spare register indexes must leave both settings alone.
        set_config(32'd1, 1'b1);
        cfg_write(CFG_SPARE_LO, $urandom());
        cfg_write(CFG_SPARE_HI, $urandom());

        // Three grants extend the mark. Freeing the middle one leaves a hole that the
        // next allocate must fill before the mark moves again. A second free of the same
        // block is refused.
        repeat (3) send_req(KIND_ALLOC, $urandom());
        send_req(KIND_FREE, 32'd2);
        send_req(KIND_FREE, 32'd2);
        send_req(KIND_ALLOC, 32'd0);
        send_req(KIND_ALLOC, 32'hffff_ffff);
        send_req(KIND_FREE, 32'd1 + NUM_BLOCKS);
        send_req(KIND_FREE, NUM_BLOCKS);
        send_req(KIND_FREE, 32'd0);

        // With the first block at the top of the number space, only index zero maps to
        // a valid block number, so the next grant overflows and is reported full.
        set_config(32'hffff_ffff, 1'b1);
        send_req(KIND_ALLOC, $urandom());
        send_req(KIND_FREE, 32'hffff_fffe);
        send_req(KIND_FREE, 32'hffff_ffff);
        send_req(KIND_ALLOC, $urandom());
        send_req(KIND_FREE, 32'hffff_ffff);
        send_req(KIND_FREE, 32'hffff_ffff);

        set_config(32'hffff_ffff, 1'b0);
        send_req(KIND_ALLOC, $urandom());
        send_req(KIND_FREE, 32'hffff_ffff);

        // Random phases, each under its own settings: small and large first blocks, the
        // top of the number space, the midpoint, and a read-only phase. One phase holds
        // off the result side for a long stretch while requests keep coming, so the
        // block fills up and stops taking requests.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: set_config(32'd1, 1'b1);
                1: set_config($urandom_range(2, 32'h000f_ffff), 1'b1);
                2: set_config(32'hffff_ffff - $urandom_range(0, 400), 1'b1);
                3: set_config(32'd1, 1'b0);
                4: set_config($urandom_range(1, 32'hffff_ffff), 1'b1);
                5: set_config(32'h8000_0000, 1'b1);
                6: set_config(32'd1, 1'b1);
                default: set_config(32'd100, 1'b1);
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 6 && n == 10) hold_results = 1'b1;
                // Occasionally the sender stops until every answer is back.
                if ($urandom_range(0, 49) == 0) drain_all();
                random_item();
            end
        end

        // A burst of allocates without idling on either side, then frees of random low
        // blocks and allocates again: the holes are refilled first fit.
        set_config(32'd1, 1'b1);
        no_idle = 1'b1;
        repeat (BURST_ITEMS) send_req(KIND_ALLOC, $urandom());
        no_idle = 1'b0;
        repeat (24) send_req(KIND_FREE, 32'd1 + $urandom_range(0, 255));
        repeat (24) send_req(KIND_ALLOC, $urandom());

        drain_all();
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
